[sv/fctlc_pkg.sv]
`timescale 1ns / 1ps

package fctlc_pkg;

  // Default ring size.
  localparam int NUM_LEDS_DEFAULT = 4;

  // Frame bytes.
  localparam logic [7:0] FRAME_START    = 8'h02;
  localparam logic [7:0] FRAME_SIZE     = 8'h01;
  localparam logic [7:0] FRAME_RESERVED = 8'h00;
  localparam logic [7:0] FRAME_END      = 8'h03;

  // Register reset values.
  localparam logic [7:0]  COMMAND_TYPE_RESET     = 8'h20;
  localparam logic [7:0]  MAX_SECONDS_RESET      = 8'd30;
  localparam logic [15:0] STEP_TICKS_RESET       = 16'd150;
  localparam logic [15:0] TICKS_PER_SECOND_RESET = 16'd1000;

  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_COMMAND_TYPE     = 2'd0,
    REG_MAX_SECONDS      = 2'd1,
    REG_STEP_TICKS       = 2'd2,
    REG_TICKS_PER_SECOND = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } opcode_t;

  typedef struct packed {
    logic       opcode;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [3:0] led_mask;
    logic       running;
    logic       command_accepted;
  } out_item_t;

endpackage

[sv/framed_command_timed_led_chaser.sv]
`timescale 1ns / 1ps

// A result transaction is offered in the cycle after its input transaction is accepted.
// Throughput: one input transaction per cycle; in_ready drops only while a result
// waits in the output register and the downstream side is stalled.
// Reset (rst, synchronous, active high) clears the deframer, the run state and the
// output register, and loads the configuration registers with their defaults.
module framed_command_timed_led_chaser #(
  parameter int NUM_LEDS = fctlc_pkg::NUM_LEDS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  fctlc_pkg::in_item_t                 in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output fctlc_pkg::out_item_t                out_data,
  input  logic                                cfg_we,
  input  logic [fctlc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [fctlc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import fctlc_pkg::*;

  localparam int LitW = $clog2(NUM_LEDS);
  localparam logic [LitW-1:0] LastLed = LitW'(NUM_LEDS - 1);

  // Deframer states, one-hot.
  typedef enum logic [5:0] {
    PS_START   = 6'b000001,
    PS_LEN     = 6'b000010,
    PS_TYPE    = 6'b000100,
    PS_PAYLOAD = 6'b001000,
    PS_RSVD    = 6'b010000,
    PS_END     = 6'b100000
  } parse_state_t;

  // Configuration registers.
  logic [7:0]  command_type;
  logic [7:0]  max_seconds;
  logic [15:0] step_ticks;
  logic [15:0] ticks_per_second;

  // Block state.
  parse_state_t    parse_state, parse_state_next;
  logic [7:0]      frame_type, frame_type_next;
  logic [7:0]      frame_payload, frame_payload_next;
  logic [LitW-1:0] lit_index, lit_index_next;
  logic            run_active, run_active_next;
  logic [23:0]     ticks_left, ticks_left_next;
  logic [15:0]     step_count, step_count_next;
  logic            accepted;
  logic [15:0]     step_inc;
  logic [23:0]     run_length;

  out_item_t result_next;
  logic      in_fire;

  // The output register parts the two sides: a new transaction is taken whenever
  // the register is empty or its content leaves in this same cycle.
  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      command_type     <= COMMAND_TYPE_RESET;
      max_seconds      <= MAX_SECONDS_RESET;
      step_ticks       <= STEP_TICKS_RESET;
      ticks_per_second <= TICKS_PER_SECOND_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_COMMAND_TYPE:     command_type     <= cfg_data[7:0];
        REG_MAX_SECONDS:      max_seconds      <= cfg_data[7:0];
        REG_STEP_TICKS:       step_ticks       <= cfg_data;
        REG_TICKS_PER_SECOND: ticks_per_second <= cfg_data;
        default: ;
      endcase
    end
  end

  // Run length in ticks; an 8 by 16 bit product exactly fills the 24-bit counter.
  assign run_length = frame_payload * ticks_per_second;
  assign step_inc   = step_count + 16'd1;

  always_comb begin
    parse_state_next   = parse_state;
    frame_type_next    = frame_type;
    frame_payload_next = frame_payload;
    lit_index_next     = lit_index;
    run_active_next    = run_active;
    ticks_left_next    = ticks_left;
    step_count_next    = step_count;
    accepted           = 1'b0;

    if (in_data.opcode == OP_BYTE) begin
      case (parse_state)
        PS_START: parse_state_next = (in_data.rx_byte == FRAME_START) ? PS_LEN : PS_START;
        PS_LEN:   parse_state_next = (in_data.rx_byte == FRAME_SIZE) ? PS_TYPE : PS_START;
        PS_TYPE: begin
          frame_type_next  = in_data.rx_byte;
          parse_state_next = PS_PAYLOAD;
        end
        PS_PAYLOAD: begin
          frame_payload_next = in_data.rx_byte;
          parse_state_next   = PS_RSVD;
        end
        PS_RSVD: parse_state_next = (in_data.rx_byte == FRAME_RESERVED) ? PS_END : PS_START;
        PS_END: begin
          // The stored type and payload must both qualify, and the end byte must match.
          accepted = (in_data.rx_byte == FRAME_END) && (frame_type == command_type) &&
                     (frame_payload != 8'd0) && (frame_payload <= max_seconds);
          parse_state_next = PS_START;
        end
        default: parse_state_next = PS_START;
      endcase

      // A valid command starts a fresh run, also on top of one in progress.
      if (accepted) begin
        run_active_next = 1'b1;
        lit_index_next  = '0;
        step_count_next = '0;
        ticks_left_next = run_length;
      end
    end else if (run_active) begin
      if (ticks_left == 24'd0) begin
        // The tick after the last counted one ends the run.
        run_active_next = 1'b0;
        lit_index_next  = '0;
        step_count_next = '0;
      end else begin
        ticks_left_next = ticks_left - 24'd1;
        if (step_inc >= step_ticks) begin
          step_count_next = '0;
          lit_index_next  = (lit_index == LastLed) ? '0 : lit_index + LitW'(1);
        end else begin
          step_count_next = step_inc;
        end
      end
    end

    // Only the first four LEDs are visible on the mask.
    for (int i = 0; i < 4; i++) begin
      result_next.led_mask[i] = run_active_next && (int'(lit_index_next) == i);
    end
    result_next.running          = run_active_next;
    result_next.command_accepted = accepted;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_state   <= PS_START;
      frame_type    <= '0;
      frame_payload <= '0;
      lit_index     <= '0;
      run_active    <= 1'b0;
      ticks_left    <= '0;
      step_count    <= '0;
    end else if (in_fire) begin
      parse_state   <= parse_state_next;
      frame_type    <= frame_type_next;
      frame_payload <= frame_payload_next;
      lit_index     <= lit_index_next;
      run_active    <= run_active_next;
      ticks_left    <= ticks_left_next;
      step_count    <= step_count_next;
    end
  end

  // Result register: loaded on every accepted input transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data <= result_next;
    end
  end

  // An idle block keeps the ring and step counter cleared.
  assert property (@(posedge clk) disable iff (rst)
    !run_active |-> (lit_index == '0) && (step_count == '0))
    else $error("idle block holds a stale LED index or step count");

  // A completed command always shows a run at LED 0.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.command_accepted |-> out_data.running && out_data.led_mask[0])
    else $error("accepted command without a run starting at LED 0");

  // At most one LED lit, and none without a run.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0(out_data.led_mask) &&
                  (out_data.running || (out_data.led_mask == 4'd0)))
    else $error("LED mask is not one-hot while running or not dark while idle");

  // Every accepted input transaction leaves a result in the output register.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted input transaction produced no result");

endmodule

[dv/led_chaser_checker.sv]
`timescale 1ns / 1ps

// Watches both channels of the LED chaser, keeps its own copy of the deframer,
// run state and settings, and compares each result with its expectation.
module led_chaser_checker #(
  parameter int NUM_LEDS = fctlc_pkg::NUM_LEDS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  fctlc_pkg::in_item_t               in_data,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  fctlc_pkg::out_item_t              out_data,
  input  logic                              cfg_we,
  input  logic [fctlc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [fctlc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                                fail_count,
  output int                                pending
);
  import fctlc_pkg::*;

  typedef enum logic [2:0] {
    WAIT_START    = 3'd0,
    WAIT_LEN      = 3'd1,
    WAIT_TYPE     = 3'd2,
    WAIT_PAYLOAD  = 3'd3,
    WAIT_RESERVED = 3'd4,
    WAIT_END      = 3'd5
  } frame_phase_t;

  // Settings as last written.
  logic [7:0]   cmd_type;
  logic [7:0]   max_secs;
  logic [15:0]  step_ticks;
  logic [15:0]  tick_rate;

  // Deframer and run state.
  frame_phase_t frame_phase;
  logic [7:0]   held_type;
  logic [7:0]   held_secs;
  int           lit_led;
  logic         run_on;
  logic [23:0]  ticks_left;
  logic [15:0]  step_cnt;

  out_item_t    led_results_q[$];

  // Applies one input transaction to the model state and returns the LED view.
  function automatic out_item_t advance_chaser(in_item_t item);
    out_item_t res;
    logic      hit;
    hit = 1'b0;
    if (opcode_t'(item.opcode) == OP_BYTE) begin
      case (frame_phase)
        WAIT_START: frame_phase = (item.rx_byte == FRAME_START) ? WAIT_LEN : WAIT_START;
        WAIT_LEN: frame_phase = (item.rx_byte == FRAME_SIZE) ? WAIT_TYPE : WAIT_START;
        WAIT_TYPE: begin
          held_type   = item.rx_byte;
          frame_phase = WAIT_PAYLOAD;
        end
        WAIT_PAYLOAD: begin
          held_secs   = item.rx_byte;
          frame_phase = WAIT_RESERVED;
        end
        WAIT_RESERVED: frame_phase = (item.rx_byte == FRAME_RESERVED) ? WAIT_END : WAIT_START;
        WAIT_END: begin
          hit = (item.rx_byte == FRAME_END) && (held_type == cmd_type) &&
                (held_secs >= 8'd1) && (held_secs <= max_secs);
          frame_phase = WAIT_START;
        end
        default: frame_phase = WAIT_START;
      endcase
      if (hit) begin
        run_on     = 1'b1;
        lit_led    = 0;
        step_cnt   = '0;
        ticks_left = 24'(32'(held_secs) * 32'(tick_rate));
      end
    end else if (run_on) begin
      if (ticks_left == '0) begin
        run_on   = 1'b0;
        lit_led  = 0;
        step_cnt = '0;
      end else begin
        ticks_left = ticks_left - 24'd1;
        step_cnt   = step_cnt + 16'd1;
        if (step_cnt >= step_ticks) begin
          step_cnt = '0;
          lit_led  = (lit_led + 1) % NUM_LEDS;
        end
      end
    end
    res.led_mask         = (run_on && lit_led < 4) ? 4'(1 << lit_led) : 4'b0;
    res.running          = run_on;
    res.command_accepted = hit;
    return res;
  endfunction

  function automatic void check_field(string name, logic [3:0] want, logic [3:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : watch
    out_item_t want;
    if (rst) begin
      cmd_type    = COMMAND_TYPE_RESET;
      max_secs    = MAX_SECONDS_RESET;
      step_ticks  = STEP_TICKS_RESET;
      tick_rate   = TICKS_PER_SECOND_RESET;
      frame_phase = WAIT_START;
      held_type   = '0;
      held_secs   = '0;
      lit_led     = 0;
      run_on      = 1'b0;
      ticks_left  = '0;
      step_cnt    = '0;
      led_results_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_COMMAND_TYPE:     cmd_type   = cfg_data[7:0];
          REG_MAX_SECONDS:      max_secs   = cfg_data[7:0];
          REG_STEP_TICKS:       step_ticks = cfg_data;
          REG_TICKS_PER_SECOND: tick_rate  = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (led_results_q.size() == 0) begin
          $display("%0t: unexpected result %h, nothing expected", $time, out_data);
          fail_count++;
        end else begin
          want = led_results_q.pop_front();
          check_field("led_mask", want.led_mask, out_data.led_mask);
          check_field("running", 4'(want.running), 4'(out_data.running));
          check_field("command_accepted", 4'(want.command_accepted),
                      4'(out_data.command_accepted));
        end
      end
      if (in_valid && in_ready)
        led_results_q.push_back(advance_chaser(in_data));
    end
    pending = led_results_q.size();
  end

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps

// Top of the LED chaser bench. It builds the stimulus, drives both channels and
// the register port, and gives the verdict. All prediction and comparison live
// in the checker instantiated next to the block.
module testbench;
  import fctlc_pkg::*;

  // Far above the slowest correct run: roughly 560 transactions, each one at
  // worst paying the longest sender gap and the longest receiver stall, plus drains.
  localparam int CYCLE_LIMIT = 100000;

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_ready;
  in_item_t               in_data;
  logic                   out_valid;
  logic                   out_ready;
  out_item_t              out_data;
  logic                   cfg_we;
  cfg_reg_t               cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int fail_count;
  int pending;
  int item_count;
  int cycle_count;
  bit idle_on;

  framed_command_timed_led_chaser i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  led_chaser_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Watchdog: a hung handshake or a result that never arrives ends up here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver side. While idling is enabled, ready drops in bursts of random length
  // between stretches of random length; otherwise it stays high.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
      end
      out_ready <= 1'b1;
      if (idle_on)
        repeat ($urandom_range(0, 6)) @(negedge clk);
    end
  end

  // Offers one transaction and returns at the falling edge after it was taken.
  // The caller is always at a falling edge, so valid is assigned at most once
  // per time step: it is either kept high for the next item or dropped for a gap.
  task automatic send_item(input opcode_t op, input logic [7:0] value);
    in_item_t item;
    item.opcode  = op;
    item.rx_byte = value;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    item_count++;
    @(negedge clk);
  endtask

  // Ticks carry a random byte as well, which the block must ignore.
  task automatic send_ticks(input int count);
    repeat (count) send_item(OP_TICK, 8'($urandom));
  endtask

  // Sends a command frame. With bad_pos in 0..5 the byte at that place is
  // flipped to some other value and the frame is cut off right after it, so
  // broken frames also leave the deframer part way through. Ticks are mixed in
  // between bytes now and then; they must not disturb the deframer.
  task automatic send_frame(input logic [7:0] ftype, input logic [7:0] secs,
                            input int bad_pos);
    logic [7:0] frame_bytes [6];
    int         last;
    frame_bytes[0] = FRAME_START;
    frame_bytes[1] = FRAME_SIZE;
    frame_bytes[2] = ftype;
    frame_bytes[3] = secs;
    frame_bytes[4] = FRAME_RESERVED;
    frame_bytes[5] = FRAME_END;
    last = 5;
    if (bad_pos >= 0) begin
      frame_bytes[bad_pos] = frame_bytes[bad_pos] ^ 8'($urandom_range(1, 255));
      last = bad_pos;
    end
    for (int k = 0; k <= last; k++) begin
      send_item(OP_BYTE, frame_bytes[k]);
      if (k < last && $urandom_range(0, 5) == 0)
        send_ticks($urandom_range(1, 3));
    end
  endtask

  // Stops offering input and waits until every result has been taken. Each
  // transaction makes exactly one result, so the block is idle after that.
  task automatic drain;
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // Writes all four registers on consecutive cycles. The unused upper byte of
  // the 8-bit registers gets random data, which the block must drop.
  task automatic load_settings(input logic [7:0] ctype, input logic [7:0] max_s,
                               input logic [15:0] step, input logic [15:0] rate);
    cfg_we    <= 1'b1;
    cfg_index <= REG_COMMAND_TYPE;
    cfg_data  <= {8'($urandom), ctype};
    @(negedge clk);
    cfg_index <= REG_MAX_SECONDS;
    cfg_data  <= {8'($urandom), max_s};
    @(negedge clk);
    cfg_index <= REG_STEP_TICKS;
    cfg_data  <= step;
    @(negedge clk);
    cfg_index <= REG_TICKS_PER_SECOND;
    cfg_data  <= rate;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // One random phase under fixed settings. Most traffic is well-formed frames
  // whose type usually matches and whose duration is usually in range, so runs
  // start, restart and time out; the rest is tick bursts, cut-off frames and
  // stray bytes.
  task automatic run_phase(input logic [7:0] ctype, input logic [7:0] max_s,
                           input logic [15:0] step, input logic [15:0] rate,
                           input int count);
    int         first;
    int         pick;
    logic [7:0] ftype;
    logic [7:0] secs;
    drain();
    load_settings(ctype, max_s, step, rate);
    first = item_count;
    while (item_count - first < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        ftype = ($urandom_range(0, 6) != 0) ? ctype : 8'($urandom);
        if (max_s != 8'd0 && $urandom_range(0, 4) != 0)
          secs = 8'($urandom_range(1, max_s));
        else
          secs = 8'($urandom);
        send_frame(ftype, secs, (pick < 50) ? -1 : $urandom_range(0, 5));
      end else if (pick < 90) begin
        send_ticks($urandom_range(1, 12));
      end else begin
        send_item(OP_BYTE, 8'($urandom));
      end
    end
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = REG_COMMAND_TYPE;
    cfg_data  = '0;
    idle_on   = 1'b1;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part: all-ones command type, widest duration limit, LED moving
    // on every tick and one tick per second, so a run is visible end to end.
    load_settings(8'hFF, 8'd255, 16'd0, 16'd1);
    send_ticks(1);                 // tick while idle changes nothing
    send_frame(8'hFF, 8'd1, 1);    // wrong length byte
    send_frame(8'hFF, 8'd1, 4);    // wrong reserved byte
    send_frame(8'hFF, 8'd2, -1);   // accepted, two seconds of ticks
    send_ticks(1);
    send_frame(8'hFF, 8'd1, -1);   // restart in the middle of a run
    send_ticks(3);                 // advance, reach the end, then idle again

    // Random phases over a spread of settings, extremes included.
    run_phase(COMMAND_TYPE_RESET, MAX_SECONDS_RESET, STEP_TICKS_RESET,
              TICKS_PER_SECOND_RESET, 60);
    run_phase(8'h00, 8'd3, 16'd2, 16'd4, 90);
    run_phase(8'($urandom), 8'd5, 16'd1, 16'd2, 90);
    run_phase(8'hA5, 8'd0, 16'd3, 16'd1, 40);             // no frame can pass
    run_phase(8'h5A, 8'd2, 16'd0, 16'd0, 60);             // run ends on first tick
    run_phase(8'($urandom), 8'd255, 16'hFFFF, 16'hFFFF, 60);

    // Last part runs at full rate on both sides.
    drain();
    idle_on = 1'b0;
    run_phase(8'($urandom), 8'd4, 16'd3, 16'd3, 130);

    drain();
    repeat (5) @(negedge clk);
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
